// ----- hdl/rtoh_pkg.sv -----
package rtoh_pkg;

  // Number of quotient bits each divider produces, one per pipeline stage.
  localparam int unsigned QuoBits = 12;
  // Numerator width of both divisions.
  localparam int unsigned NumBits = 20;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  // One converted result.
  typedef struct packed {
    logic [14:0] hue_out;
    logic [7:0]  sat_out;
    logic [7:0]  val_out;
    logic        achromatic;
  } hsv_t;

  // Hue sector, with the red sector split by the sign of its difference.
  typedef enum logic [1:0] {
    SEC_RED_LO = 2'd0,
    SEC_RED_HI = 2'd1,
    SEC_GREEN  = 2'd2,
    SEC_BLUE   = 2'd3
  } sector_e;

  // Classified pixel handed from the front to the divider pipeline.
  typedef struct packed {
    logic [NumBits-1:0] num_h;
    logic [NumBits-1:0] num_s;
    logic [7:0]         den_h;
    logic [7:0]         den_s;
    logic               neg;
    sector_e            sector;
    logic [7:0]         val;
    logic               achro;
  } work_t;

  // Sector offset in Q9.6 degrees.
  function automatic logic [14:0] sector_offset(input sector_e sec);
    logic [14:0] off;
    unique case (sec)
      SEC_RED_LO: off = 15'd0;
      SEC_RED_HI: off = 15'd23040;
      SEC_GREEN:  off = 15'd7680;
      SEC_BLUE:   off = 15'd15360;
      default:    off = 15'd0;
    endcase
    return off;
  endfunction

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                          input logic [7:0] den);
    logic [8:0] t;
    logic [8:0] r;
    t = {rem, nbit};
    if (t >= {1'b0, den}) begin
      r = t - {1'b0, den};
      return {r[7:0], 1'b1};
    end
    return {t[7:0], 1'b0};
  endfunction

endpackage

// ----- hdl/rtoh_front.sv -----
module rtoh_front import rtoh_pkg::*; (
  input  pixel_t pixel_i,
  output work_t  work_o
);

  logic [7:0] r, g, b, mx, mn, delta, mag;
  logic [8:0] diff;
  logic       neg;
  sector_e    sec;

  // Largest and smallest channel.
  always_comb begin
    r = pixel_i.red_in;
    g = pixel_i.green_in;
    b = pixel_i.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
  end

  // Sector choice, blue first, then green, then red.
  always_comb begin
    if (b == mx) begin
      diff = {1'b0, r} - {1'b0, g};
      sec  = SEC_BLUE;
    end else if (g == mx) begin
      diff = {1'b0, b} - {1'b0, r};
      sec  = SEC_GREEN;
    end else begin
      diff = {1'b0, g} - {1'b0, b};
      sec  = (g >= b) ? SEC_RED_LO : SEC_RED_HI;
    end
    neg = diff[8];
    mag = neg ? 8'(-diff) : diff[7:0];
  end

  // Numerators: 3840 times the difference, and 255 times delta scaled by 16.
  always_comb begin
    work_o.num_h  = {8'd0, mag, 4'd0} * NumBits'(240);
    work_o.num_s  = ({12'd0, delta} * NumBits'(255)) << 4;
    work_o.den_h  = delta;
    work_o.den_s  = mx;
    work_o.neg    = neg;
    work_o.sector = sec;
    work_o.val    = mx;
    work_o.achro  = (delta == 8'd0);
  end

endmodule

// ----- hdl/rtoh_fifo.sv -----
module rtoh_fifo import rtoh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  output logic  valid_o,
  output work_t data_o
);

  work_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  // The back end drains a beat whenever one is present.
  assign pop     = (count_q != 2'd0);
  assign valid_o = pop;
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/rtoh_back.sv -----
module rtoh_back import rtoh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  done_o,
  output hsv_t  result_o
);

  logic                    vld_q   [QuoBits+1];
  logic [7:0]              rem_h_q [QuoBits+1];
  logic [7:0]              rem_s_q [QuoBits+1];
  logic [QuoBits-1:0]      sh_h_q  [QuoBits+1];
  logic [QuoBits-1:0]      sh_s_q  [QuoBits+1];
  logic [QuoBits-1:0]      q_h_q   [QuoBits+1];
  logic [QuoBits-1:0]      q_s_q   [QuoBits+1];
  work_t                   w_q     [QuoBits+1];
  logic [8:0]              st_h    [QuoBits];
  logic [8:0]              st_s    [QuoBits];
  logic                    done_q;
  hsv_t                    res_q;
  logic [14:0]             off, qh;

  // One quotient bit per stage for both divisions.
  always_comb begin
    for (int k = 0; k < QuoBits; k++) begin
      st_h[k] = div_step(rem_h_q[k], sh_h_q[k][QuoBits-1], w_q[k].den_h);
      st_s[k] = div_step(rem_s_q[k], sh_s_q[k][QuoBits-1], w_q[k].den_s);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QuoBits; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < QuoBits; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    rem_h_q[0] <= work_i.num_h[NumBits-1:QuoBits];
    rem_s_q[0] <= work_i.num_s[NumBits-1:QuoBits];
    sh_h_q[0]  <= work_i.num_h[QuoBits-1:0];
    sh_s_q[0]  <= work_i.num_s[QuoBits-1:0];
    q_h_q[0]   <= '0;
    q_s_q[0]   <= '0;
    w_q[0]     <= work_i;
    for (int k = 0; k < QuoBits; k++) begin
      rem_h_q[k+1] <= st_h[k][8:1];
      rem_s_q[k+1] <= st_s[k][8:1];
      sh_h_q[k+1]  <= {sh_h_q[k][QuoBits-2:0], 1'b0};
      sh_s_q[k+1]  <= {sh_s_q[k][QuoBits-2:0], 1'b0};
      q_h_q[k+1]   <= {q_h_q[k][QuoBits-2:0], st_h[k][0]};
      q_s_q[k+1]   <= {q_s_q[k][QuoBits-2:0], st_s[k][0]};
      w_q[k+1]     <= w_q[k];
    end
  end

  // Hue from offset and signed quotient; gray input forces zeros.
  always_comb begin
    off = sector_offset(w_q[QuoBits].sector);
    qh  = {3'd0, q_h_q[QuoBits]};
  end

  always_ff @(posedge clk_i) begin
    if (w_q[QuoBits].achro) begin
      res_q.hue_out <= 15'd0;
      res_q.sat_out <= 8'd0;
    end else begin
      res_q.hue_out <= w_q[QuoBits].neg ? (off - qh) : (off + qh);
      res_q.sat_out <= q_s_q[QuoBits][QuoBits-1:4];
    end
    res_q.val_out    <= w_q[QuoBits].val;
    res_q.achromatic <= w_q[QuoBits].achro;
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QuoBits];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/rgb_to_hsv_converter.sv -----
// Channel   Direction  Handshake          Payload
// command   in         start / busy       pixel_i  (red, green, blue)
// result    out        done_o strobe      result_o (hue, sat, val, achromatic)
//
// A pixel is taken at each edge with start high and busy low, one per cycle.
// Each result's strobe follows its pixel through the queue slot, a load stage,
// twelve divider stages (one quotient bit each) and the output register.
// Reset clears the queue count and all stage valid bits.
// The receiver cannot stall; the back end takes the queue head every cycle,
// so the two-entry queue never fills and busy stays low.
module rgb_to_hsv_converter import rtoh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel_i,
  output logic   done_o,
  output hsv_t   result_o
);

  work_t work, head;
  logic  full, head_vld, push;

  assign push = start && !busy;
  assign busy = full;

  // Classify the pixel.
  rtoh_front u_front (
    .pixel_i (pixel_i),
    .work_o  (work)
  );

  // Queue between front and divider.
  rtoh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work),
    .full_o  (full),
    .valid_o (head_vld),
    .data_o  (head)
  );

  // Pipelined divisions and result.
  rtoh_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (head_vld),
    .work_i   (head),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rtoh_pkg::*;

  // Result checker: holds predicted HSV values in pixel order.
  class hsv_scoreboard;
    hsv_t pending_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Predicts the conversion of one accepted pixel.
    function void note_pixel(pixel_t px);
      int   r, g, b, mx, mn, delta, d, offset;
      hsv_t exp_res;
      r = px.red_in;
      g = px.green_in;
      b = px.blue_in;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      exp_res.val_out = mx[7:0];
      if (delta == 0) begin
        exp_res.hue_out = '0;
        exp_res.sat_out = '0;
        exp_res.achromatic = 1'b1;
      end else begin
        exp_res.achromatic = 1'b0;
        exp_res.sat_out = 8'((delta * 255) / mx);
        if (b == mx) begin
          d = r - g;
          offset = 240;
        end else if (g == mx) begin
          d = b - r;
          offset = 120;
        end else begin
          d = g - b;
          offset = (g >= b) ? 0 : 360;
        end
        // Integer division truncates toward zero.
        exp_res.hue_out = 15'((3840 * d) / delta + offset * 64);
      end
      pending_q.push_back(exp_res);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_result(hsv_t act);
      hsv_t exp_res;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (act.hue_out !== exp_res.hue_out) begin
        $display("%0t: hue expected %0d actual %0d", $time, exp_res.hue_out, act.hue_out);
        errors++;
      end
      if (act.sat_out !== exp_res.sat_out) begin
        $display("%0t: sat expected %0d actual %0d", $time, exp_res.sat_out, act.sat_out);
        errors++;
      end
      if (act.val_out !== exp_res.val_out) begin
        $display("%0t: val expected %0d actual %0d", $time, exp_res.val_out, act.val_out);
        errors++;
      end
      if (act.achromatic !== exp_res.achromatic) begin
        $display("%0t: achromatic expected %b actual %b", $time, exp_res.achromatic,
                 act.achromatic);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  pixel_t pixel_i;
  logic   done_o;
  hsv_t   result_o;

  hsv_scoreboard board;
  int unsigned   cycle_count;
  int unsigned   idle_pct;

  localparam int unsigned CycleLimit = 200000;

  rgb_to_hsv_converter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor, with a cycle limit as a watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) board.check_result(result_o);
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sends one pixel: random idle gaps, then holds start until the beat is taken.
  // Start stays high afterwards so the next pixel can follow without a gap.
  task automatic send_pixel(input pixel_t px);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
    board.note_pixel(px);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    pixel_t px;
    px.red_in = 8'(r);
    px.green_in = 8'(g);
    px.blue_in = 8'(b);
    send_pixel(px);
  endtask

  // Random pixel, often with ties or extreme channels to hit sector edges.
  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = pixel_t'(24'($urandom));
    case ($urandom_range(5))
      0: px.green_in = px.red_in;
      1: px.blue_in = px.green_in;
      2: px.blue_in = px.red_in;
      3: px.red_in = $urandom_range(1) ? 8'd255 : 8'd0;
      default: ;
    endcase
    return px;
  endfunction

  // Stops sending, then waits for every pending result.
  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    cycle_count = 0;
    idle_pct = 0;
    start = 1'b0;
    pixel_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, gray, primaries, ties and both red half-sectors.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(255, 255, 254);
    send_rgb(200, 10, 200);
    send_rgb(255, 10, 20);
    send_rgb(255, 20, 10);
    send_rgb(1, 0, 0);
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(255, 254, 0);
    send_rgb(254, 0, 255);
    send_rgb(255, 0, 1);
    send_rgb(170, 85, 0);

    // Pause until the pipeline has delivered every pending result.
    wait_drained();

    // Random phases with different sender idle rates.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 53;
        2: idle_pct = 28;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < 385; i++) send_pixel(rand_pixel());
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
